### rtl/core/jkse_pkg.sv
// shared types, constants and helper functions of the json key string extractor
// no dependencies; imported by every module of the block
package jkse_pkg;

  // sizes fixed by the interface
  localparam int BYTE_W              = 8;
  localparam int KEY_REG_COUNT       = 4;
  localparam int KEY_REG_W           = 64;
  localparam int KEY_BYTES           = KEY_REG_COUNT * KEY_REG_W / BYTE_W;
  localparam int KEY_IDX_W           = 6;
  localparam int KEY_MAX_BYTES       = 32;
  localparam int CFG_IDX_W           = 3;
  localparam int MAX_RES             = 6;
  localparam int RES_CNT_W           = 3;
  localparam int VALUE_COUNT_BITS_DEF = 13;
  localparam int CAP_RESET_BITS      = 9;
  localparam int VALUE_CAP_RESET     = 256;
  localparam int HELD_DIGITS         = 3;
  localparam int HEX_CNT_W           = 2;
  localparam int ACC_W               = 12;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_CAP = 3'd5;

  // characters
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_QMARK     = 8'h3f;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0c;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // one result transaction
  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
  } res_item_t;

  // all results caused by one document byte
  typedef struct packed {
    res_item_t [MAX_RES-1:0] items;
    logic [RES_CNT_W-1:0]    cnt;
  } res_batch_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
  endfunction

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t h;
    h = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(ch - 8'h37);
    end
    return h;
  endfunction

endpackage

### rtl/core/jkse_cfg_regs.sv
// configuration registers: key bytes, key length and value capacity
// depends on jkse_pkg
module jkse_cfg_regs
  import jkse_pkg::*;
#(
  parameter int VALUE_COUNT_BITS = VALUE_COUNT_BITS_DEF,
  parameter int CAP_W            = (VALUE_COUNT_BITS > CAP_RESET_BITS) ?
                                   VALUE_COUNT_BITS : CAP_RESET_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [CFG_IDX_W-1:0]          wr_index,
  input  logic [KEY_REG_W-1:0]          wr_data,
  output logic [KEY_BYTES-1:0][7:0]     key_bytes,
  output logic [KEY_IDX_W-1:0]          key_len,
  output logic [CAP_W-1:0]              value_cap
);

  logic [KEY_REG_COUNT-1:0][KEY_REG_W-1:0] key_r;
  logic [KEY_IDX_W-1:0]                    key_len_r;
  logic [CAP_W-1:0]                        cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      key_len_r <= KEY_IDX_W'(1);
      cap_r     <= CAP_W'(VALUE_CAP_RESET);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KEY_0:     key_r[0]  <= wr_data;
        REG_KEY_1:     key_r[1]  <= wr_data;
        REG_KEY_2:     key_r[2]  <= wr_data;
        REG_KEY_3:     key_r[3]  <= wr_data;
        REG_KEY_LEN:   key_len_r <= wr_data[KEY_IDX_W-1:0];
        REG_VALUE_CAP: cap_r     <= CAP_W'(wr_data[VALUE_COUNT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  assign key_bytes = key_r;
  // lengths beyond the supported maximum are clamped
  assign key_len   = (key_len_r > KEY_IDX_W'(KEY_MAX_BYTES)) ?
                     KEY_IDX_W'(KEY_MAX_BYTES) : key_len_r;
  assign value_cap = cap_r;

endmodule

### rtl/core/jkse_scanner.sv
// parser state and combinational scan of one document byte into a result batch
// depends on jkse_pkg
module jkse_scanner
  import jkse_pkg::*;
#(
  parameter int VALUE_COUNT_BITS = VALUE_COUNT_BITS_DEF,
  parameter int CAP_W            = (VALUE_COUNT_BITS > CAP_RESET_BITS) ?
                                   VALUE_COUNT_BITS : CAP_RESET_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [7:0]                doc_byte,
  input  logic                      doc_end,
  input  logic [KEY_BYTES-1:0][7:0] key_bytes,
  input  logic [KEY_IDX_W-1:0]      key_len,
  input  logic [CAP_W-1:0]          value_cap,
  output res_batch_t                batch
);

  localparam int CMP_W = CAP_W + 1;

  typedef enum logic [2:0] {
    PH_SEARCH, PH_KEY, PH_AFTER_KEY, PH_VALUE_WS, PH_STRING, PH_ESCAPE, PH_UHEX
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic [KEY_IDX_W-1:0] kmi;
    logic                 ws_clr;
  } key_step_t;

  // one key character against the key byte at idx
  function automatic key_step_t key_char(input logic [KEY_IDX_W-1:0] idx,
                                         input logic [7:0] ch,
                                         input logic [KEY_IDX_W-1:0] len,
                                         input logic [7:0] kb);
    key_step_t s;
    s.phase  = PH_SEARCH;
    s.kmi    = idx;
    s.ws_clr = 1'b0;
    if (idx < len) begin
      if (ch == kb) begin
        s.phase = PH_KEY;
        s.kmi   = idx + KEY_IDX_W'(1);
      end else if (ch == CH_QUOTE) begin
        s.phase = PH_KEY;
        s.kmi   = '0;
      end
    end else if (ch == CH_QUOTE) begin
      s.phase  = PH_AFTER_KEY;
      s.ws_clr = 1'b1;
    end
    return s;
  endfunction

  phase_t                     phase_r, phase_nxt;
  logic [KEY_IDX_W-1:0]       kmi_r, kmi_nxt;
  logic                       ws_r, ws_nxt;
  logic [7:0]                 held_r [HELD_DIGITS];
  logic [7:0]                 held_nxt [HELD_DIGITS];
  logic [HEX_CNT_W-1:0]       hdc_r, hdc_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [VALUE_COUNT_BITS-1:0] stored_r, stored_nxt;
  logic                       fin_r, fin_nxt;

  logic                       last;
  logic                       scan;
  hex_t                       hex;
  logic [7:0]                 kb_cur;
  key_step_t                  ks;
  logic [7:0]                 att [MAX_RES];
  logic [RES_CNT_W-1:0]       n;
  logic [RES_CNT_W-1:0]       ns;
  logic                       fin_hit;
  logic                       fin_arg;
  logic                       enter_string;
  logic [MAX_RES-1:0]         room_ok;
  res_item_t                  fin_item;

  assign last = doc_end || (doc_byte == CH_NUL);
  assign scan = !fin_r && (doc_byte != CH_NUL);
  assign hex  = hex_decode(doc_byte);
  assign kb_cur = (kmi_r >= KEY_IDX_W'(KEY_BYTES)) ? 8'h00 :
                  key_bytes[kmi_r[$clog2(KEY_BYTES)-1:0]];

  always_comb begin
    phase_nxt    = phase_r;
    kmi_nxt      = kmi_r;
    ws_nxt       = ws_r;
    held_nxt     = held_r;
    hdc_nxt      = hdc_r;
    acc_nxt      = acc_r;
    fin_hit      = 1'b0;
    fin_arg      = 1'b0;
    enter_string = 1'b0;
    ks           = '0;
    n            = '0;
    for (int i = 0; i < MAX_RES; i++) att[i] = '0;

    if (scan) begin
      unique case (phase_r)
        PH_KEY: begin
          ks = key_char(kmi_r, doc_byte, key_len, kb_cur);
          phase_nxt = ks.phase;
          kmi_nxt   = ks.kmi;
          if (ks.ws_clr) ws_nxt = 1'b0;
        end
        PH_AFTER_KEY: begin
          if (doc_byte == CH_COLON) begin
            phase_nxt = PH_VALUE_WS;
          end else if (is_ws(doc_byte)) begin
            ws_nxt = 1'b1;
          end else if (ws_r) begin
            if (doc_byte == CH_QUOTE) begin
              phase_nxt = PH_KEY;
              kmi_nxt   = '0;
            end else begin
              phase_nxt = PH_SEARCH;
            end
          end else begin
            // closing quote of the failed key reopens a key
            ks = key_char('0, doc_byte, key_len, key_bytes[0]);
            phase_nxt = ks.phase;
            kmi_nxt   = ks.kmi;
            if (ks.ws_clr) ws_nxt = 1'b0;
          end
        end
        PH_VALUE_WS: begin
          if (!is_ws(doc_byte)) begin
            if (doc_byte == CH_QUOTE) begin
              phase_nxt    = PH_STRING;
              enter_string = 1'b1;
            end else begin
              fin_hit = 1'b1;
            end
          end
        end
        PH_STRING: begin
          if (doc_byte == CH_QUOTE) begin
            fin_hit = 1'b1;
            fin_arg = 1'b1;
          end else if (doc_byte == CH_BACKSLASH) begin
            phase_nxt = PH_ESCAPE;
          end else begin
            att[n] = doc_byte;
            n = n + RES_CNT_W'(1);
          end
        end
        PH_ESCAPE: begin
          phase_nxt = PH_STRING;
          unique case (doc_byte)
            CH_N: begin att[n] = CH_LF; n = n + RES_CNT_W'(1); end
            CH_T: begin att[n] = CH_TAB; n = n + RES_CNT_W'(1); end
            CH_R: begin att[n] = CH_CR; n = n + RES_CNT_W'(1); end
            CH_B: begin att[n] = CH_BS; n = n + RES_CNT_W'(1); end
            CH_F: begin att[n] = CH_FF; n = n + RES_CNT_W'(1); end
            CH_U: begin
              phase_nxt = PH_UHEX;
              hdc_nxt   = '0;
              acc_nxt   = '0;
            end
            default: begin att[n] = doc_byte; n = n + RES_CNT_W'(1); end
          endcase
        end
        PH_UHEX: begin
          if (hex.ok) begin
            if (hdc_r < HEX_CNT_W'(HELD_DIGITS)) begin
              held_nxt[hdc_r] = doc_byte;
              hdc_nxt = hdc_r + HEX_CNT_W'(1);
              acc_nxt = {acc_r[ACC_W-5:0], hex.val};
            end else begin
              // code points of 0x80 and above become a question mark
              att[n] = (acc_r[ACC_W-1:3] == '0) ? {acc_r[3:0], hex.val} : CH_QMARK;
              n = n + RES_CNT_W'(1);
              phase_nxt = PH_STRING;
              hdc_nxt   = '0;
            end
          end else begin
            // broken escape: question mark, held digits, then the byte as content unless it is a quote or backslash
            att[n] = CH_QMARK;
            n = n + RES_CNT_W'(1);
            for (int i = 0; i < HELD_DIGITS; i++) begin
              if (HEX_CNT_W'(i) < hdc_r) begin
                att[n] = held_r[i];
                n = n + RES_CNT_W'(1);
              end
            end
            hdc_nxt   = '0;
            phase_nxt = PH_STRING;
            if (doc_byte == CH_QUOTE) begin
              fin_hit = 1'b1;
              fin_arg = 1'b1;
            end else if (doc_byte == CH_BACKSLASH) begin
              phase_nxt = PH_ESCAPE;
            end else begin
              att[n] = doc_byte;
              n = n + RES_CNT_W'(1);
            end
          end
        end
        default: begin
          if (doc_byte == CH_QUOTE) begin
            phase_nxt = PH_KEY;
            kmi_nxt   = '0;
          end else begin
            phase_nxt = PH_SEARCH;
          end
        end
      endcase
    end

    // end of document closes whatever is pending
    if (last && !fin_r && !fin_hit) begin
      fin_hit = 1'b1;
      unique case (phase_nxt)
        PH_STRING: fin_arg = 1'b1;
        PH_ESCAPE: begin
          att[n] = CH_BACKSLASH;
          n = n + RES_CNT_W'(1);
          fin_arg = 1'b1;
        end
        PH_UHEX: begin
          att[n] = CH_QMARK;
          n = n + RES_CNT_W'(1);
          for (int i = 0; i < HELD_DIGITS; i++) begin
            if (HEX_CNT_W'(i) < hdc_nxt) begin
              att[n] = held_nxt[i];
              n = n + RES_CNT_W'(1);
            end
          end
          fin_arg = 1'b1;
        end
        default: fin_arg = 1'b0;
      endcase
    end
  end

  // capacity check: emit k is kept while stored + k + 1 < capacity
  always_comb begin
    ns = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      room_ok[k] = (CMP_W'(stored_r) + CMP_W'(k + 1)) < CMP_W'(value_cap);
      if (RES_CNT_W'(k) < n && room_ok[k]) ns = ns + RES_CNT_W'(1);
    end
  end

  always_comb begin
    fin_item            = '0;
    fin_item.done_res   = 1'b1;
    fin_item.found      = fin_arg && (value_cap != '0);
    batch.cnt           = ns + RES_CNT_W'(fin_hit);
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < ns) begin
        batch.items[k].value_byte = att[k];
        batch.items[k].byte_valid = 1'b1;
        batch.items[k].done_res   = 1'b0;
        batch.items[k].found      = 1'b0;
      end else if (RES_CNT_W'(k) == ns && fin_hit) begin
        batch.items[k] = fin_item;
      end else begin
        batch.items[k] = '0;
      end
    end
  end

  always_comb begin
    stored_nxt = enter_string ? '0 : stored_r + VALUE_COUNT_BITS'(ns);
    fin_nxt    = fin_r || fin_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      kmi_r    <= '0;
      ws_r     <= 1'b0;
      hdc_r    <= '0;
      stored_r <= '0;
      fin_r    <= 1'b0;
    end else if (step_en) begin
      if (last) begin
        phase_r  <= PH_SEARCH;
        kmi_r    <= '0;
        ws_r     <= 1'b0;
        hdc_r    <= '0;
        stored_r <= '0;
        fin_r    <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        kmi_r    <= kmi_nxt;
        ws_r     <= ws_nxt;
        hdc_r    <= hdc_nxt;
        stored_r <= stored_nxt;
        fin_r    <= fin_nxt;
      end
    end
  end

  // digit payload, only read below the digit count
  always_ff @(posedge clk) begin
    if (step_en) begin
      held_r <= held_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

### rtl/core/jkse_result_buf.sv
// result register: holds one batch and hands it out one transaction per cycle while out_ready is high
// depends on jkse_pkg
module jkse_result_buf
  import jkse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_batch_t batch,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output res_item_t  out_item
);

  res_item_t [MAX_RES-1:0] items_r;
  logic [RES_CNT_W-1:0]    cnt_r;
  logic [RES_CNT_W-1:0]    ptr_r;
  logic [RES_CNT_W-1:0]    remain;

  assign remain    = cnt_r - ptr_r;
  assign out_valid = (remain != '0);
  // refill as the last waiting transaction leaves
  assign can_load  = (remain == '0) || ((remain == RES_CNT_W'(1)) && out_ready);
  assign out_item  = (ptr_r < RES_CNT_W'(MAX_RES)) ? items_r[ptr_r] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (load) begin
      cnt_r <= batch.cnt;
      ptr_r <= '0;
    end else if (out_valid && out_ready) begin
      ptr_r <= ptr_r + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items_r <= batch.items;
    end
  end

endmodule

### rtl/core/json_key_string_extractor.sv
// json key string extractor: input byte register, combinational scan, result register
// throughput: one byte per cycle while the result register can take its batch; a byte
//   with k results holds that register until all k have left (k is at most six, MAX_RES)
// reset: synchronous active-low rst_n clears parser state; key 0, key_length 1, capacity 256
// depends on jkse_pkg, jkse_cfg_regs, jkse_scanner, jkse_result_buf
module json_key_string_extractor
  import jkse_pkg::*;
#(
  parameter int VALUE_COUNT_BITS = VALUE_COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // document byte stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] doc_byte
  input  logic                 in_tlast,   // doc_end
  // extracted value stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] value_byte
  output logic [1:0]           out_tuser,  // [0] byte_valid, [1] found
  output logic                 out_tlast,  // done_res
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_REG_W-1:0] cfg_data
);

  localparam int CAP_W = (VALUE_COUNT_BITS > CAP_RESET_BITS) ?
                         VALUE_COUNT_BITS : CAP_RESET_BITS;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  logic                      step_en;
  logic                      can_load;
  logic [KEY_BYTES-1:0][7:0] key_bytes;
  logic [KEY_IDX_W-1:0]      key_len;
  logic [CAP_W-1:0]          value_cap;
  res_batch_t                batch;
  res_item_t                 cur_item;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  jkse_cfg_regs #(
    .VALUE_COUNT_BITS (VALUE_COUNT_BITS),
    .CAP_W            (CAP_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .key_bytes (key_bytes),
    .key_len   (key_len),
    .value_cap (value_cap)
  );

  // a byte leaves the input register when the result register can take its batch
  assign step_en   = in_valid_r && can_load;
  // the input register takes a new transaction when it is empty or its byte leaves
  assign in_tready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // byte payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  jkse_scanner #(
    .VALUE_COUNT_BITS (VALUE_COUNT_BITS),
    .CAP_W            (CAP_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .doc_byte  (in_byte_r),
    .doc_end   (in_end_r),
    .key_bytes (key_bytes),
    .key_len   (key_len),
    .value_cap (value_cap),
    .batch     (batch)
  );

  jkse_result_buf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .batch     (batch),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (cur_item)
  );

  assign out_tdata = cur_item.value_byte;
  assign out_tuser = {cur_item.found, cur_item.byte_valid};
  assign out_tlast = cur_item.done_res;

  // the done transaction never carries a value byte
  a_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser[0])
    else $error("done transaction flagged as value byte");

  // found is only reported on the done transaction
  a_found_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("found set outside done transaction");

  // a held byte only waits behind pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step_en |-> out_tvalid)
    else $error("input byte stalled with no pending result");

  // a byte waiting in the input register is not lost
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step_en |=> in_valid_r && $stable(in_byte_r))
    else $error("stalled document byte dropped");

endmodule
